// ----- rtl/core/bara_pkg.sv -----
// Shared constants and types for the bit array range operation block.
package bara_pkg;

  localparam int STORE_BITS_DEF = 1024;
  localparam int POS_W          = 10;
  localparam int ANS_W          = 11;
  localparam int MODE_W         = 3;
  localparam int WORD_W         = 32;
  localparam int BYTE_W         = 8;

  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SET   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_FLIP  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_COUNT = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RUN   = 3'd4;

  typedef struct packed {
    logic             run_mode;
    logic [ANS_W-1:0] run;
    logic [ANS_W-1:0] acc;
  } scan_t;

endpackage

// ----- rtl/core/bara_byte_unit.sv -----
// Shared scan unit: folds one byte of masked store data into the count or run state.
module bara_byte_unit import bara_pkg::*; (
  input  logic [BYTE_W-1:0] bits_in,
  input  scan_t             scan_in,
  output scan_t             scan_out
);

  logic [ANS_W-1:0] run;
  logic [ANS_W-1:0] acc;

  always_comb begin
    run = scan_in.run;
    acc = scan_in.acc;
    for (int i = 0; i < BYTE_W; i++) begin
      if (scan_in.run_mode) begin
        run = bits_in[i] ? run + ANS_W'(1) : '0;
        if (run > acc) begin
          acc = run;
        end
      end else begin
        acc = acc + ANS_W'(bits_in[i]);
      end
    end
    scan_out.run_mode = scan_in.run_mode;
    scan_out.run      = run;
    scan_out.acc      = acc;
  end

endmodule

// ----- rtl/core/bit_array_range_ops.sv -----
// Top level: bit array with range clear/set/invert, ones count and longest ones run.
// The bit array lives in a 32-bit wide memory; writes handle one word per cycle.
// A write mode (clear, set, invert) first reads the range's first word, then does a
// read-modify-write of each word in turn with the next word's read overlapped, and
// then the block is ready again. A query (count, longest run) reads each word in
// turn and the shared scan unit folds one byte of the word per cycle into the count
// or run state; then the result register is loaded. An empty write or an unused
// mode leaves the block ready at once; an empty query goes straight to the result
// load. The result load waits while an earlier answer is still held on the output.
// The store starts cleared: per-word valid bits reset with the block, so no
// clearing pass runs.
module bit_array_range_ops import bara_pkg::*; #(
  parameter int STORE_BITS = STORE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [MODE_W-1:0] mode,
  input  logic [POS_W-1:0]  lo,
  input  logic [POS_W-1:0]  hi,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [ANS_W-1:0]  answer
);

  localparam int STORE_WORDS = (STORE_BITS + WORD_W - 1) / WORD_W;
  localparam int POS_WORDS   = (1 << POS_W) / WORD_W;
  localparam int MEM_WORDS   = (STORE_WORDS < POS_WORDS) ? STORE_WORDS : POS_WORDS;
  localparam int AW          = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int MAX_POS     = (1 << POS_W) - 1;
  localparam int LAST_POS    = (STORE_BITS - 1 < MAX_POS) ? STORE_BITS - 1 : MAX_POS;
  localparam logic [POS_W-1:0] LAST = POS_W'(LAST_POS);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_PROC, S_OUT} state_t;

  state_t          state;
  logic [MODE_W-1:0] op;
  logic [4:0]      lo_b;
  logic [4:0]      hi_b;
  logic [AW-1:0]   wlo;
  logic [AW-1:0]   whi;
  logic [AW-1:0]   cur;
  logic [1:0]      bi;
  scan_t           scan;
  scan_t           scan_next;

  logic [WORD_W-1:0] mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] vld;
  logic [WORD_W-1:0] q;
  logic              q_vld;

  logic [POS_W-1:0]  hi_c;
  logic              empty;
  logic              is_write;
  logic              first;
  logic              last;
  logic [WORD_W-1:0] mask;
  logic [WORD_W-1:0] data;
  logic [WORD_W-1:0] masked;
  logic [WORD_W-1:0] wdata;
  logic              rd_en;
  logic              wr_en;
  logic [AW-1:0]     rd_addr;

  assign in_ready = (state == S_IDLE);
  assign hi_c     = (hi > LAST) ? LAST : hi;
  assign empty    = (lo > hi_c);
  assign is_write = (op == MODE_CLEAR) || (op == MODE_SET) || (op == MODE_FLIP);
  assign first    = (cur == wlo);
  assign last     = (cur == whi);

  always_comb begin
    mask = '1;
    if (first) begin
      mask = mask & (32'hFFFF_FFFF << lo_b);
    end
    if (last) begin
      mask = mask & (32'hFFFF_FFFF >> (5'd31 - hi_b));
    end
    data   = q_vld ? q : '0;
    masked = data & mask;
    case (op)
      MODE_CLEAR: wdata = data & ~mask;
      MODE_SET:   wdata = data | mask;
      default:    wdata = data ^ mask;
    endcase
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cur;
    wr_en   = 1'b0;
    if (state == S_READ) begin
      rd_en = 1'b1;
    end else if (state == S_PROC) begin
      wr_en   = is_write;
      rd_addr = cur + AW'(1);
      rd_en   = !last && (is_write || bi == 2'd3);
    end
  end

  bara_byte_unit u_scan (
    .bits_in  (masked[{bi, 3'b000} +: BYTE_W]),
    .scan_in  (scan),
    .scan_out (scan_next)
  );

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[cur] <= wdata;
    end
    if (rd_en) begin
      q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      q_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[cur] <= 1'b1;
      end
      if (rd_en) begin
        q_vld <= vld[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            op            <= mode;
            lo_b          <= lo[4:0];
            hi_b          <= hi_c[4:0];
            wlo           <= AW'(lo[POS_W-1:5]);
            whi           <= AW'(hi_c[POS_W-1:5]);
            cur           <= AW'(lo[POS_W-1:5]);
            bi            <= '0;
            scan.run_mode <= (mode == MODE_RUN);
            scan.run      <= '0;
            scan.acc      <= '0;
            if (mode == MODE_CLEAR || mode == MODE_SET || mode == MODE_FLIP) begin
              if (!empty) begin
                state <= S_READ;
              end
            end else if (mode == MODE_COUNT || mode == MODE_RUN) begin
              state <= empty ? S_OUT : S_READ;
            end
          end
        end
        S_READ: begin
          state <= S_PROC;
        end
        S_PROC: begin
          if (is_write) begin
            if (last) begin
              state <= S_IDLE;
            end else begin
              cur <= cur + AW'(1);
            end
          end else begin
            scan <= scan_next;
            bi   <= bi + 2'd1;
            if (bi == 2'd3) begin
              if (last) begin
                state <= S_OUT;
              end else begin
                cur <= cur + AW'(1);
              end
            end
          end
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            answer    <= scan.acc;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/core/bara_checker.sv -----
// Port-level checker for the bit array range operation block, with its bind.
module bara_checker import bara_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic [MODE_W-1:0] mode,
  input logic [POS_W-1:0]  lo,
  input logic [POS_W-1:0]  hi,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ANS_W-1:0]  answer
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(answer))
    else $error("result word dropped or changed while stalled");

  a_answer_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> answer <= 11'd1024)
    else $error("answer exceeds array size");

  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (mode == MODE_CLEAR || mode == MODE_SET || mode == MODE_FLIP)
    |=> !$rose(out_valid))
    else $error("write mode produced a result word");

  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (mode == MODE_COUNT || mode == MODE_RUN) |=> !in_ready)
    else $error("ready while a query is in progress");

endmodule

bind bit_array_range_ops bara_checker u_bara_checker (.*);

// ----- tb/tb_bit_array_range_ops.sv -----
// Self-checking testbench for bit_array_range_ops: range clear/set/invert, ones count, longest run.
module tb_bit_array_range_ops;
  timeunit 1ns;
  timeprecision 1ps;
  import bara_pkg::*;

  localparam int NBITS = STORE_BITS_DEF;
  localparam int HOLD_LEN = 300;
  localparam int TAIL_CYCLES = 200;
  localparam int MAX_REPORTS = 10;
  localparam logic [MODE_W-1:0] MODE_SPARE_FIRST = 3'd5;
  localparam logic [MODE_W-1:0] MODE_SPARE_LAST  = 3'd7;
  localparam logic [POS_W-1:0]  POS_LAST = POS_W'(NBITS - 1);

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_ready;
  logic [MODE_W-1:0] mode;
  logic [POS_W-1:0]  lo;
  logic [POS_W-1:0]  hi;
  logic              out_valid;
  logic              out_ready;
  logic [ANS_W-1:0]  answer;

  logic [NBITS-1:0]  bit_image;
  logic [ANS_W-1:0]  pending_answers[$];
  int                errors;
  bit                idle_on;
  bit                hold_req;

  bit_array_range_ops dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .lo        (lo),
    .hi        (hi),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .answer    (answer)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb_bit_array_range_ops failed");
    $finish;
  end

  // Applies one word to the bit image; returns 1 when the word yields an answer.
  function automatic bit apply_range_op(input logic [MODE_W-1:0] m, input logic [POS_W-1:0] l,
                                        input logic [POS_W-1:0] h, output logic [ANS_W-1:0] ans);
    int p;
    int top;
    int acc;
    int run;
    bit blank;
    acc = 0;
    run = 0;
    ans = '0;
    top = (int'(h) >= NBITS) ? NBITS - 1 : int'(h);
    blank = (int'(l) > top) || (int'(l) >= NBITS);
    if (m > MODE_RUN) return 1'b0;
    if (m == MODE_CLEAR || m == MODE_SET || m == MODE_FLIP) begin
      if (!blank) begin
        for (p = int'(l); p <= top; p++) begin
          case (m)
            MODE_CLEAR: bit_image[p] = 1'b0;
            MODE_SET:   bit_image[p] = 1'b1;
            default:    bit_image[p] = ~bit_image[p];
          endcase
        end
      end
      return 1'b0;
    end
    if (!blank) begin
      for (p = int'(l); p <= top; p++) begin
        if (m == MODE_COUNT) begin
          if (bit_image[p]) acc++;
        end else begin
          run = bit_image[p] ? run + 1 : 0;
          if (run > acc) acc = run;
        end
      end
    end
    ans = ANS_W'(acc);
    return 1'b1;
  endfunction

  // Called at a rising edge; returns at the edge where the word is taken.
  task automatic send_word(input logic [MODE_W-1:0] m, input logic [POS_W-1:0] l,
                           input logic [POS_W-1:0] h);
    logic [ANS_W-1:0] ans;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1'b1;
    mode <= m;
    lo <= l;
    hi <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (apply_range_op(m, l, h, ans)) pending_answers.push_back(ans);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic random_words(input int count);
    logic [MODE_W-1:0] m;
    logic [POS_W-1:0]  l;
    logic [POS_W-1:0]  h;
    int k;
    int pick;
    int span;
    for (k = 0; k < count; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 5) m = MODE_W'($urandom_range(MODE_SPARE_FIRST, MODE_SPARE_LAST));
      else if (pick < 45) m = MODE_W'($urandom_range(MODE_CLEAR, MODE_FLIP));
      else m = MODE_W'($urandom_range(MODE_COUNT, MODE_RUN));
      l = POS_W'($urandom_range(0, NBITS - 1));
      pick = $urandom_range(0, 9);
      if (pick < 6) span = $urandom_range(0, 40);
      else if (pick < 8) span = $urandom_range(0, 300);
      else span = NBITS;
      if (pick == 9) h = POS_W'($urandom_range(0, NBITS - 1));
      else h = (int'(l) + span > NBITS - 1) ? POS_LAST : POS_W'(int'(l) + span);
      send_word(m, l, h);
    end
  endtask

  task automatic test_cleared_store();
    send_word(MODE_COUNT, '0, POS_LAST);
    send_word(MODE_RUN, '0, POS_LAST);
  endtask

  task automatic test_single_bit_load();
    send_word(MODE_SET, '0, '0);
    send_word(MODE_SET, POS_LAST, POS_LAST);
    send_word(MODE_SET, 10'd31, 10'd31);
    send_word(MODE_SET, 10'd32, 10'd32);
    send_word(MODE_SET, 10'd33, 10'd33);
    send_word(MODE_COUNT, '0, POS_LAST);
    send_word(MODE_RUN, '0, POS_LAST);
    send_word(MODE_COUNT, POS_LAST, POS_LAST);
  endtask

  task automatic test_range_writes();
    send_word(MODE_SET, 10'd100, 10'd200);
    send_word(MODE_FLIP, 10'd150, 10'd160);
    send_word(MODE_RUN, '0, POS_LAST);
    send_word(MODE_RUN, 10'd120, 10'd155);
    send_word(MODE_CLEAR, 10'd31, 10'd120);
    send_word(MODE_COUNT, '0, POS_LAST);
  endtask

  task automatic test_empty_ranges();
    send_word(MODE_CLEAR, 10'd161, 10'd160);
    send_word(MODE_FLIP, POS_LAST, '0);
    send_word(MODE_COUNT, 10'd900, 10'd10);
    send_word(MODE_RUN, POS_LAST, '0);
  endtask

  task automatic test_spare_modes();
    logic [MODE_W-1:0] m;
    for (m = MODE_SPARE_FIRST; m != MODE_CLEAR; m++) send_word(m, '0, POS_LAST);
  endtask

  // Whole array set gives the widest answer; sender then waits for all answers.
  task automatic test_full_range();
    send_word(MODE_SET, '0, POS_LAST);
    send_word(MODE_COUNT, '0, POS_LAST);
    send_word(MODE_RUN, '0, POS_LAST);
    wait_drain();
    send_word(MODE_CLEAR, '0, POS_LAST);
    send_word(MODE_COUNT, '0, POS_LAST);
  endtask

  task automatic test_output_stall();
    int k;
    hold_req = 1'b1;
    for (k = 0; k < 40; k++)
      send_word(MODE_W'($urandom_range(MODE_COUNT, MODE_RUN)),
                POS_W'($urandom_range(0, 63)), POS_W'($urandom_range(0, 127)));
  endtask

  task automatic test_random_mix();
    random_words(550);
  endtask

  task automatic test_random_streaming();
    idle_on = 1'b0;
    random_words(160);
  endtask

  initial begin
    int n;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        for (n = 0; n < HOLD_LEN; n++) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    logic [ANS_W-1:0] want;
    if (!rst && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        if (errors < MAX_REPORTS) $display("unexpected answer %0d", answer);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (answer !== want) begin
          if (errors < MAX_REPORTS) $display("answer mismatch: expected %0d got %0d", want, answer);
          errors++;
        end
      end
    end
  end

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    mode <= MODE_CLEAR;
    lo <= '0;
    hi <= '0;
    bit_image = '0;
    errors = 0;
    idle_on = 1'b1;
    hold_req = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_cleared_store();
    test_single_bit_load();
    test_range_writes();
    test_empty_ranges();
    test_spare_modes();
    test_full_range();
    test_output_stall();
    test_random_mix();
    test_random_streaming();
    wait_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("tb_bit_array_range_ops passed");
    end else begin
      $display("tb_bit_array_range_ops failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/bara_pkg.sv
rtl/core/bara_byte_unit.sv
rtl/core/bit_array_range_ops.sv
rtl/core/bara_checker.sv
tb/tb_bit_array_range_ops.sv
